// ----- sv/inverse_park_clarke_q15_assert.svh -----
// Assertion macros shared by the inverse Park/Clarke checker.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef INVERSE_PARK_CLARKE_Q15_ASSERT_SVH
`define INVERSE_PARK_CLARKE_Q15_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define IPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define IPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/ipc_pkg.sv -----
// Package for the inverse Park / inverse Clarke pipeline: constants, payload
// structs, saturation helper and the elaboration-time sine table generator.
package ipc_pkg;

  localparam int IPC_ANGLE_BITS = 10;
  localparam int IPC_DEPTH      = 6;   // register stages from input to output
  localparam int IPC_CNT_W      = $clog2(IPC_DEPTH + 1);

  localparam logic [17:0] SQRT3_Q15 = 18'd56756;
  localparam logic [63:0] HALF_PI_Q61 = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q61 = 64'h2000000000000000;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
    logic signed [15:0] volt_d;
    logic signed [15:0] volt_q;
  } trig_t;

  typedef struct packed {
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
  } ab_t;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -20'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Q61 product, low 64 bits of (a*b) >> 61.
  function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[124:61];
  endfunction

  // Unsigned 64-bit quotient by shift and subtract, one quotient bit per step.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Taylor series on [0, pi/4] in Q61; odd selects sine, else cosine.
  function automatic logic [63:0] series(input logic [63:0] x, input logic odd);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] dv;
    x2   = mul_q61(x, x);
    term = odd ? x : ONE_Q61;
    pos  = term;
    neg  = '0;
    for (int n = 1; n <= 12; n++) begin
      dv   = odd ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
      term = udiv64(mul_q61(term, x2), dv);
      if ((n % 2) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return pos - neg;
  endfunction

  // Quarter-wave entry k: round(32767 * sin(pi/2 * k / Q)), Q = 2^(ab-2).
  function automatic logic [14:0] rom_entry(input int ab, input int k);
    int           s;
    int           q;
    int           kk;
    logic [63:0]  v;
    logic [127:0] p;
    s  = ab - 2;
    q  = 1 << s;
    kk = (k > q) ? q : k;
    if (2 * kk <= q) begin
      p = {64'd0, HALF_PI_Q61} * 128'(kk);
      v = series(64'(p >> s), 1'b1);
    end else begin
      p = {64'd0, HALF_PI_Q61} * 128'(q - kk);
      v = series(64'(p >> s), 1'b0);
    end
    p = {64'd0, v} * 128'd32767 + (128'd1 << 60);
    return p[75:61];
  endfunction

endpackage

// ----- sv/inverse_park_clarke_q15.sv -----
// Top level of the Q15 inverse Park + inverse Clarke pipeline.
// Depends on ipc_pkg, ipc_sincos, ipc_rotate and ipc_clarke.
//
// Usage:
//   Input channel (in_valid/in_ready) carries a Q15 d/q voltage pair and a
//   16-bit electrical angle (65536 counts per turn). Output channel
//   (out_valid/out_ready) returns three Q15 phase voltages, one result per
//   input transfer, in order.
//   Stages from input transfer to out_valid, in order: table lookup,
//   Park products, Park sums, sqrt(3) product, phase B, phase C.
//   Throughput: one transfer per cycle while out_ready is high; every
//   stage is a register with its own valid bit, and nothing iterates.
//   Stall: when out_ready is low, the last stage holds its result and each
//   earlier stage advances only into an empty slot, so bubbles collapse and
//   in_ready stays high while any slot is free. Nothing is dropped or
//   repeated.
//   Reset: rst_n low clears every valid bit on the next edge; the sine
//   table is constant, so the block accepts input right after reset.
//   Only the top ANGLE_BITS bits of the angle address the table.
module inverse_park_clarke_q15 import ipc_pkg::*; #(
  parameter int ANGLE_BITS = IPC_ANGLE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_volt_d,
  input  logic signed [15:0] in_volt_q,
  input  logic        [15:0] in_elec_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_phase_a,
  output logic signed [15:0] out_phase_b,
  output logic signed [15:0] out_phase_c
);

  // Handshake between stage groups
  logic  trig_valid;
  logic  trig_ready;
  trig_t trig_data;
  logic  ab_valid;
  logic  ab_ready;
  ab_t   ab_data;

  // Stage 1: angle to sine and cosine
  ipc_sincos #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_sincos (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_ready  (in_ready),
    .volt_d    (in_volt_d),
    .volt_q    (in_volt_q),
    .elec_angle(in_elec_angle),
    .dn_valid  (trig_valid),
    .dn_ready  (trig_ready),
    .dn_data   (trig_data)
  );

  // Stages 2-3: rotate d/q into alpha/beta
  ipc_rotate u_rotate (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(trig_valid),
    .up_ready(trig_ready),
    .up_data (trig_data),
    .dn_valid(ab_valid),
    .dn_ready(ab_ready),
    .dn_data (ab_data)
  );

  // Stages 4-6: alpha/beta to three phases; last stage drives the outputs
  ipc_clarke u_clarke (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(ab_valid),
    .up_ready(ab_ready),
    .up_data (ab_data),
    .dn_valid(out_valid),
    .dn_ready(out_ready),
    .phase_a (out_phase_a),
    .phase_b (out_phase_b),
    .phase_c (out_phase_c)
  );

endmodule

// ----- sv/ipc_sincos.sv -----
// Sine/cosine lookup stage: quarter-wave constant table plus quadrant folding.
// Depends on ipc_pkg (rom_entry, trig_t, quad_t).
module ipc_sincos import ipc_pkg::*; #(
  parameter int ANGLE_BITS = IPC_ANGLE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  logic signed [15:0] volt_d,
  input  logic signed [15:0] volt_q,
  input  logic        [15:0] elec_angle,
  output logic               dn_valid,
  input  logic               dn_ready,
  output trig_t              dn_data
);

  localparam int R_W     = ANGLE_BITS - 2;
  localparam int A_W     = ANGLE_BITS - 1;
  localparam int QUARTER = 1 << R_W;

  typedef logic [14:0] rom_arr_t [QUARTER + 1];

  function automatic rom_arr_t build_rom();
    rom_arr_t t;
    for (int k = 0; k <= QUARTER; k++) begin
      t[k] = rom_entry(ANGLE_BITS, k);
    end
    return t;
  endfunction

  localparam rom_arr_t SIN_ROM = build_rom();

  logic [ANGLE_BITS-1:0] idx;
  quad_t                 quad;
  logic [A_W-1:0]        fwd_addr;
  logic [A_W-1:0]        rev_addr;
  logic signed [15:0]    fwd;
  logic signed [15:0]    rev;
  logic signed [15:0]    sin_nxt;
  logic signed [15:0]    cos_nxt;
  logic                  v_r;
  trig_t                 data_r;
  logic                  adv;

  assign idx      = elec_angle[15 -: ANGLE_BITS];
  assign quad     = quad_t'(idx[ANGLE_BITS-1 -: 2]);
  assign fwd_addr = {1'b0, idx[R_W-1:0]};
  assign rev_addr = A_W'(QUARTER) - fwd_addr;
  assign fwd      = $signed({1'b0, SIN_ROM[fwd_addr]});
  assign rev      = $signed({1'b0, SIN_ROM[rev_addr]});

  always_comb begin
    unique case (quad)
      QUAD_I: begin
        sin_nxt = fwd;
        cos_nxt = rev;
      end
      QUAD_II: begin
        sin_nxt = rev;
        cos_nxt = -fwd;
      end
      QUAD_III: begin
        sin_nxt = -fwd;
        cos_nxt = -rev;
      end
      default: begin
        sin_nxt = -rev;
        cos_nxt = fwd;
      end
    endcase
  end

  assign adv      = !v_r || dn_ready;
  assign up_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      data_r <= '{sin_v: sin_nxt, cos_v: cos_nxt, volt_d: volt_d, volt_q: volt_q};
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = data_r;

endmodule

// ----- sv/ipc_rotate.sv -----
// Inverse Park stages: four products, then sums scaled by 1/32768 and saturated.
// Depends on ipc_pkg (trig_t, ab_t, sat16).
module ipc_rotate import ipc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  trig_t up_data,
  output logic  dn_valid,
  input  logic  dn_ready,
  output ab_t   dn_data
);

  logic               v1_r;
  logic               v2_r;
  logic               adv1;
  logic               adv2;
  logic signed [31:0] p_cd_r;
  logic signed [31:0] p_sq_r;
  logic signed [31:0] p_sd_r;
  logic signed [31:0] p_cq_r;
  logic signed [32:0] alpha_sum;
  logic signed [32:0] beta_sum;
  logic signed [32:0] alpha_bias;
  logic signed [32:0] beta_bias;
  logic signed [17:0] alpha_div;
  logic signed [17:0] beta_div;
  ab_t                ab_r;

  assign adv2     = !v2_r || dn_ready;
  assign adv1     = !v1_r || adv2;
  assign up_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= up_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && up_valid) begin
      p_cd_r <= up_data.cos_v * up_data.volt_d;
      p_sq_r <= up_data.sin_v * up_data.volt_q;
      p_sd_r <= up_data.sin_v * up_data.volt_d;
      p_cq_r <= up_data.cos_v * up_data.volt_q;
    end
  end

  // Divide by 32768 truncating toward zero: bias negatives before the shift.
  assign alpha_sum  = 33'(p_cd_r) - 33'(p_sq_r);
  assign beta_sum   = 33'(p_sd_r) + 33'(p_cq_r);
  assign alpha_bias = alpha_sum + (alpha_sum[32] ? 33'sd32767 : 33'sd0);
  assign beta_bias  = beta_sum + (beta_sum[32] ? 33'sd32767 : 33'sd0);
  assign alpha_div  = alpha_bias[32:15];
  assign beta_div   = beta_bias[32:15];

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      ab_r.alpha <= sat16(20'(alpha_div));
      ab_r.beta  <= sat16(20'(beta_div));
    end
  end

  assign dn_valid = v2_r;
  assign dn_data  = ab_r;

endmodule

// ----- sv/ipc_clarke.sv -----
// Inverse Clarke stages: sqrt(3) scaling of beta, phase B, then phase C.
// Depends on ipc_pkg (ab_t, sat16, SQRT3_Q15).
module ipc_clarke import ipc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  ab_t                up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output logic signed [15:0] phase_a,
  output logic signed [15:0] phase_b,
  output logic signed [15:0] phase_c
);

  logic               v1_r;
  logic               v2_r;
  logic               v3_r;
  logic               adv1;
  logic               adv2;
  logic               adv3;
  logic signed [33:0] prod_r;
  logic signed [15:0] alpha1_r;
  logic signed [33:0] prod_bias;
  logic signed [18:0] t_div;
  logic signed [19:0] num;
  logic signed [19:0] num_bias;
  logic signed [15:0] pb_nxt;
  logic signed [15:0] pa2_r;
  logic signed [15:0] pb2_r;
  logic signed [17:0] pc_sum;
  logic signed [15:0] pa_r;
  logic signed [15:0] pb_r;
  logic signed [15:0] pc_r;

  assign adv3     = !v3_r || dn_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign up_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= up_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && up_valid) begin
      prod_r   <= 34'($signed(SQRT3_Q15)) * 34'(up_data.beta);
      alpha1_r <= up_data.alpha;
    end
  end

  // Both divisions truncate toward zero.
  assign prod_bias = prod_r + (prod_r[33] ? 34'sd32767 : 34'sd0);
  assign t_div     = prod_bias[33:15];
  assign num       = 20'(t_div) - 20'(alpha1_r);
  assign num_bias  = num + (num[19] ? 20'sd1 : 20'sd0);
  assign pb_nxt    = sat16(num_bias >>> 1);

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      pa2_r <= alpha1_r;
      pb2_r <= pb_nxt;
    end
  end

  assign pc_sum = -(18'(pa2_r) + 18'(pb2_r));

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      pa_r <= pa2_r;
      pb_r <= pb2_r;
      pc_r <= sat16(20'(pc_sum));
    end
  end

  assign dn_valid = v3_r;
  assign phase_a  = pa_r;
  assign phase_b  = pb_r;
  assign phase_c  = pc_r;

endmodule

// ----- sv/ipc_checker.sv -----
// Port-level checker for inverse_park_clarke_q15, bound to the top level.
// Depends on ipc_pkg and inverse_park_clarke_q15_assert.svh.
`include "inverse_park_clarke_q15_assert.svh"

module ipc_checker import ipc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [15:0] in_volt_d,
  input logic signed [15:0] in_volt_q,
  input logic        [15:0] in_elec_angle,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_phase_a,
  input logic signed [15:0] out_phase_b,
  input logic signed [15:0] out_phase_c
);

  logic                 in_xfer;
  logic                 out_xfer;
  logic [IPC_CNT_W-1:0] pending_r;
  logic [IPC_CNT_W-1:0] pending_nxt;
  logic signed [17:0]   pc_sum;
  logic signed [15:0]   pc_exp;
  logic                 in_seen;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  // Input payload is not checked here; fold it in so every port is read.
  assign in_seen  = ^{in_volt_d, in_volt_q, in_elec_angle} || 1'b1;

  always_comb begin
    pending_nxt = pending_r;
    if (in_xfer && !out_xfer) begin
      pending_nxt = pending_r + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      pending_nxt = pending_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  assign pc_sum = -(18'(out_phase_a) + 18'(out_phase_b));
  assign pc_exp = sat16(20'(pc_sum));

  `IPC_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "out_valid high after reset")
  `IPC_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_phase_a) && $stable(out_phase_b) && $stable(out_phase_c), "stalled result changed")
  `IPC_ASSERT(a_occupancy, in_seen && pending_r <= IPC_CNT_W'(IPC_DEPTH) && (!out_valid || pending_r != '0), "result without pending item or overfull")
  `IPC_ASSERT(a_phase_c, out_valid |-> out_phase_c == pc_exp, "phase C not minus sum of A and B")

endmodule

bind inverse_park_clarke_q15 ipc_checker u_ipc_checker (.*);

// ----- sim/ipc_phase_checker.sv -----
`timescale 1ns / 100ps
// Checker for the Q15 inverse Park / inverse Clarke block: watches both channels,
// predicts the three phase voltages of every input transfer and compares them in order.
// Depends on ipc_pkg for the angle width and the quadrant codes.
module ipc_phase_checker import ipc_pkg::*; #(
  parameter int ANGLE_BITS = IPC_ANGLE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_volt_d,
  input  logic signed [15:0] in_volt_q,
  input  logic        [15:0] in_elec_angle,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_phase_a,
  input  logic signed [15:0] out_phase_b,
  input  logic signed [15:0] out_phase_c,
  output int                 fail_count,
  output int                 pending_count
);

  localparam int          QUARTER     = 1 << (ANGLE_BITS - 2);
  localparam logic [63:0] PI_HALF_Q61 = 64'h3243F6A8885A308D;
  localparam logic [63:0] UNITY_Q61   = 64'h2000000000000000;
  localparam longint      ROOT3_Q15   = 56756;
  localparam int          REPORT_MAX  = 10;

  typedef struct packed {
    logic signed [15:0] phase_a;
    logic signed [15:0] phase_b;
    logic signed [15:0] phase_c;
  } phases_t;

  typedef struct {
    phases_t     phases;
    logic [15:0] volt_d;
    logic [15:0] volt_q;
    logic [15:0] angle;
  } phase_expect_t;

  longint        quarter_sine [0:QUARTER];
  phase_expect_t expected_phases [$];

  // Q61 fixed-point product.
  function automatic logic [63:0] fix_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[124:61];
  endfunction

  // Truncated Taylor series in Q61: sine when odd_terms is set, else cosine.
  function automatic logic [63:0] trig_series(input logic [63:0] x, input logic odd_terms);
    logic [63:0] x_sq;
    logic [63:0] term;
    logic [63:0] plus_sum;
    logic [63:0] minus_sum;
    logic [63:0] divisor;
    x_sq      = fix_mul(x, x);
    term      = odd_terms ? x : UNITY_Q61;
    plus_sum  = term;
    minus_sum = '0;
    for (int n = 1; n <= 12; n++) begin
      divisor = odd_terms ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
      term    = fix_mul(term, x_sq) / divisor;
      if ((n % 2) == 1) begin
        minus_sum = minus_sum + term;
      end else begin
        plus_sum = plus_sum + term;
      end
    end
    return plus_sum - minus_sum;
  endfunction

  // Quarter-wave entry k, rounded half up from 32767 * sin.
  function automatic longint sine_entry(input int k);
    logic [127:0] prod;
    logic [63:0]  value;
    if (2 * k <= QUARTER) begin
      prod  = {64'd0, PI_HALF_Q61} * 128'(k);
      value = trig_series(64'(prod >> (ANGLE_BITS - 2)), 1'b1);
    end else begin
      prod  = {64'd0, PI_HALF_Q61} * 128'(QUARTER - k);
      value = trig_series(64'(prod >> (ANGLE_BITS - 2)), 1'b0);
    end
    prod = {64'd0, value} * 128'd32767 + (128'd1 << 60);
    return longint'(prod[124:61]);
  endfunction

  function automatic longint clip16(input longint v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  // Rotate d/q into alpha/beta, then split into three phases.
  function automatic phases_t predict_phases(input logic signed [15:0] volt_d,
                                             input logic signed [15:0] volt_q,
                                             input logic [15:0] angle);
    logic [15:0] idx;
    quad_t       quad;
    int          offset;
    longint      fwd;
    longint      rev;
    longint      sin_v;
    longint      cos_v;
    longint      vd;
    longint      vq;
    longint      alpha;
    longint      beta;
    longint      pa;
    longint      pb;
    longint      pc;
    phases_t     result;
    idx    = angle >> (16 - ANGLE_BITS);
    quad   = quad_t'(idx[ANGLE_BITS-1 -: 2]);
    offset = int'(idx) & (QUARTER - 1);
    fwd    = quarter_sine[offset];
    rev    = quarter_sine[QUARTER - offset];
    case (quad)
      QUAD_I: begin
        sin_v = fwd;
        cos_v = rev;
      end
      QUAD_II: begin
        sin_v = rev;
        cos_v = -fwd;
      end
      QUAD_III: begin
        sin_v = -fwd;
        cos_v = -rev;
      end
      default: begin
        sin_v = -rev;
        cos_v = fwd;
      end
    endcase
    vd    = longint'(volt_d);
    vq    = longint'(volt_q);
    alpha = clip16((cos_v * vd - sin_v * vq) / 32768);
    beta  = clip16((sin_v * vd + cos_v * vq) / 32768);
    pa    = alpha;
    pb    = clip16((-alpha + (ROOT3_Q15 * beta) / 32768) / 2);
    pc    = clip16(-(pa + pb));
    result.phase_a = 16'(pa);
    result.phase_b = 16'(pb);
    result.phase_c = 16'(pc);
    return result;
  endfunction

  initial begin
    fail_count    = 0;
    pending_count = 0;
    for (int k = 0; k <= QUARTER; k++) begin
      quarter_sine[k] = sine_entry(k);
    end
  end

  always @(posedge clk) begin
    phase_expect_t want;
    phases_t       got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want.phases = predict_phases(in_volt_d, in_volt_q, in_elec_angle);
        want.volt_d = in_volt_d;
        want.volt_q = in_volt_q;
        want.angle  = in_elec_angle;
        expected_phases.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = {out_phase_a, out_phase_b, out_phase_c};
        if (expected_phases.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= REPORT_MAX) begin
            $display("unexpected result a=%0d b=%0d c=%0d", got.phase_a, got.phase_b,
                     got.phase_c);
          end
        end else begin
          want = expected_phases.pop_front();
          if (want.phases !== got) begin
            fail_count = fail_count + 1;
            if (fail_count <= REPORT_MAX) begin
              $display("mismatch d=%0d q=%0d angle=%0d: expected a=%0d b=%0d c=%0d, got a=%0d b=%0d c=%0d",
                       $signed(want.volt_d), $signed(want.volt_q), want.angle,
                       want.phases.phase_a, want.phases.phase_b, want.phases.phase_c,
                       got.phase_a, got.phase_b, got.phase_c);
            end
          end
        end
      end
      pending_count <= expected_phases.size();
    end
  end

endmodule

// ----- sim/tb_inverse_park_clarke_q15.sv -----
`timescale 1ns / 100ps
// Top of the inverse Park / inverse Clarke testbench: clock, reset, stimulus and verdict.
// Depends on ipc_pkg, the block inverse_park_clarke_q15 and the checker ipc_phase_checker.
module tb_inverse_park_clarke_q15;
  import ipc_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int CYCLE_LIMIT  = 200000;  // slowest legal run stays far below this
  localparam int DRAIN_CYCLES = 20;      // longer than the six-stage pipeline
  localparam int RESET_CYCLES = 12;

  localparam logic signed [15:0] VOLT_MAX = 16'sh7FFF;
  localparam logic signed [15:0] VOLT_MIN = 16'sh8000;

  // Corner angles: the start of the turn and the four odd octants, where d/q extremes
  // push alpha or beta, and then the phases, into saturation.
  localparam logic [15:0] CORNER_ANGLES [5] = '{16'd0, 16'd8192, 16'd24576, 16'd40960,
                                                16'd57344};

  // Receiver behavior, switched after each random stretch.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PATTERN
  } rx_mode_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic signed [15:0] in_volt_d     = '0;
  logic signed [15:0] in_volt_q     = '0;
  logic        [15:0] in_elec_angle = '0;
  logic               out_ready     = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic signed [15:0] out_phase_a;
  logic signed [15:0] out_phase_b;
  logic signed [15:0] out_phase_c;

  int fail_count;
  int pending_count;
  int cycle_count = 0;

  rx_mode_t    rx_mode     = RX_OPEN;
  int          rx_hold     = 0;
  logic [15:0] rx_pattern  = 16'hFFFF;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  inverse_park_clarke_q15 u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_volt_d     (in_volt_d),
    .in_volt_q     (in_volt_q),
    .in_elec_angle (in_elec_angle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_phase_a   (out_phase_a),
    .out_phase_b   (out_phase_b),
    .out_phase_c   (out_phase_c)
  );

  ipc_phase_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_volt_d     (in_volt_d),
    .in_volt_q     (in_volt_q),
    .in_elec_angle (in_elec_angle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_phase_a   (out_phase_a),
    .out_phase_b   (out_phase_b),
    .out_phase_c   (out_phase_c),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: pick a mode and hold it for a random stretch. The open mode gives
  // runs with no back-pressure at all; the rotating pattern keeps at least one
  // ready bit per byte so the output never starves for good.
  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_mode    <= rx_mode_t'($urandom_range(0, 3));
      rx_hold    <= $urandom_range(16, 96);
      rx_pattern <= 16'($urandom) | 16'h0101;
    end else begin
      rx_hold    <= rx_hold - 1;
      rx_pattern <= {rx_pattern[14:0], rx_pattern[15]};
    end
    case (rx_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_LIGHT:   out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY:   out_ready <= ($urandom_range(0, 3) == 0);
      default:    out_ready <= rx_pattern[15];
    endcase
  end

  // Present one item and hold it until the block takes the transfer.
  task automatic send_item(input logic signed [15:0] volt_d, input logic signed [15:0] volt_q,
                           input logic [15:0] angle);
    in_volt_d     <= volt_d;
    in_volt_q     <= volt_q;
    in_elec_angle <= angle;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid for a gap between bursts; a zero gap keeps the stream back to back.
  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Voltages lean toward the rails so saturation of alpha, beta and the phases
  // shows up often; the rest is full-range or near zero.
  function automatic logic signed [15:0] pick_volt();
    case ($urandom_range(0, 9))
      0:       return VOLT_MIN;
      1:       return VOLT_MAX;
      2:       return 16'($signed($urandom_range(0, 511)) - 256);
      3:       return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(30000, 32767))
                                                  : 16'(-$signed($urandom_range(30000, 32768)));
      default: return 16'($urandom);
    endcase
  endfunction

  // Angles are mostly uniform; some sit near a quadrant boundary.
  function automatic logic [15:0] pick_angle();
    if ($urandom_range(0, 4) == 0) begin
      return 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 127) - 64);
    end
    return 16'($urandom);
  endfunction

  initial begin
    int sent;
    int burst;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Rail-to-rail d/q pairs at the corner angles.
    foreach (CORNER_ANGLES[ai]) begin
      send_item(VOLT_MAX, VOLT_MAX, CORNER_ANGLES[ai]);
      send_item(VOLT_MAX, VOLT_MIN, CORNER_ANGLES[ai]);
      send_item(VOLT_MIN, VOLT_MAX, CORNER_ANGLES[ai]);
      send_item(VOLT_MIN, VOLT_MIN, CORNER_ANGLES[ai]);
    end
    // Zero command, the cardinal angles, the last count of the turn, and an angle
    // whose only set bits lie below the table resolution.
    send_item(16'sd0, 16'sd0, 16'd0);
    send_item(VOLT_MAX, 16'sd0, 16'd16384);
    send_item(VOLT_MAX, 16'sd0, 16'd32768);
    send_item(VOLT_MAX, 16'sd0, 16'd49152);
    send_item(VOLT_MIN, VOLT_MAX, 16'd65535);
    send_item(VOLT_MAX, VOLT_MIN, 16'h003F);

    // Random bursts with random gaps.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst; i++) begin
        send_item(pick_volt(), pick_volt(), pick_angle());
        sent++;
      end
      pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
    end

    // Drain: wait for every expected result, then give stray results time to show.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
